// ----- hw/rtl/length_prefixed_frame_decoder_core_defines.svh -----
// Assertion macros for the length-prefixed frame decoder.
// Included by the top level; no other dependencies.
`ifndef LENGTH_PREFIXED_FRAME_DECODER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DECODER_CORE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define LPFD_ASSERT_AT(lbl, clk_sig, rst_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Concurrent assertion on the block clock clk and reset rst_n.
`define LPFD_ASSERT(lbl, prop, msg) `LPFD_ASSERT_AT(lbl, clk, rst_n, prop, msg)

`endif

// ----- hw/rtl/lpfd_pkg.sv -----
// Shared types and constants for the length-prefixed frame decoder.
// No dependencies; imported by the interfaces and all modules.
package lpfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 32;
    localparam int HDR_CNT_W = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [HDR_CNT_W-1:0] HDR_BYTES      = 3'd4;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_INDEX = 3'd3;
    localparam logic [LEN_W-1:0]     MAX_PAYLOAD_RESET = 32'd1048576;

    // Register word index of max_payload_bytes
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TRUNCATED = 3'd1,
        STATUS_TOO_LARGE = 3'd2,
        STATUS_EXCESS    = 3'd3,
        STATUS_BAD_UTF8  = 3'd4
    } status_t;

    // Bound on the next continuation byte
    typedef enum logic [1:0] {
        RANGE_NORMAL  = 2'd0,
        RANGE_RAISED  = 2'd1,
        RANGE_LOWERED = 2'd2
    } utf8_range_t;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              status_valid;
        status_t           status;
    } result_t;

endpackage

// ----- hw/rtl/lpfd_if.sv -----
// Handshake channel interfaces for the frame decoder: byte input and result output.
// Depends on lpfd_pkg.
interface lpfd_byte_if import lpfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface lpfd_result_if import lpfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              status_valid;
    status_t           status;

    modport source (output valid, output payload_valid, output payload_byte,
                    output status_valid, output status, input ready);
    modport sink (input valid, input payload_valid, input payload_byte,
                  input status_valid, input status, output ready);
endinterface

// ----- hw/rtl/lpfd_utf8.sv -----
// Strict UTF-8 sequence checker, one payload byte per step.
// Depends on lpfd_pkg.
module lpfd_utf8 import lpfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              clear,
    input  logic [BYTE_W-1:0] data_byte,
    output logic              bad_next
);

    logic [1:0]  pending_reg, pending_next;
    utf8_range_t range_reg, range_next;
    logic        error_reg, error_next;
    logic [BYTE_W-1:0] lo, hi;

    always_comb
    begin
        lo           = 8'h80;
        hi           = 8'hBF;
        pending_next = pending_reg;
        range_next   = range_reg;
        error_next   = error_reg;
        if (pending_reg != 2'd0)
        begin
            case (range_reg)
                RANGE_RAISED:  lo = (pending_reg == 2'd2) ? 8'hA0 : 8'h90;
                RANGE_LOWERED: hi = (pending_reg == 2'd2) ? 8'h9F : 8'h8F;
                default: ;
            endcase
            if ((data_byte < lo) || (data_byte > hi))
            begin
                error_next   = 1'b1;
                pending_next = 2'd0;
            end
            else
            begin
                pending_next = pending_reg - 2'd1;
            end
            range_next = RANGE_NORMAL;
        end
        else
        begin
            range_next = RANGE_NORMAL;
            if (data_byte <= 8'h7F)
            begin
                pending_next = 2'd0;
            end
            else if ((data_byte >= 8'hC2) && (data_byte <= 8'hDF))
            begin
                pending_next = 2'd1;
            end
            else if ((data_byte >= 8'hE0) && (data_byte <= 8'hEF))
            begin
                pending_next = 2'd2;
                if (data_byte == 8'hE0)
                    range_next = RANGE_RAISED;
                else if (data_byte == 8'hED)
                    range_next = RANGE_LOWERED;
            end
            else if ((data_byte >= 8'hF0) && (data_byte <= 8'hF4))
            begin
                pending_next = 2'd3;
                if (data_byte == 8'hF0)
                    range_next = RANGE_RAISED;
                else if (data_byte == 8'hF4)
                    range_next = RANGE_LOWERED;
            end
            else
            begin
                error_next = 1'b1;
            end
        end
    end

    // Verdict after this byte when stepping, else so far: either a hard error or an unfinished sequence
    assign bad_next = step ? (error_next || (pending_next != 2'd0))
                           : (error_reg || (pending_reg != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            range_reg   <= RANGE_NORMAL;
            error_reg   <= 1'b0;
        end
        else if (clear)
        begin
            pending_reg <= 2'd0;
            range_reg   <= RANGE_NORMAL;
            error_reg   <= 1'b0;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            range_reg   <= range_next;
            error_reg   <= error_next;
        end
    end

endmodule

// ----- hw/rtl/lpfd_frame.sv -----
// Frame tracker: header assembly, length accounting, verdict selection.
// Depends on lpfd_pkg and lpfd_utf8.
module lpfd_frame import lpfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              buffer_end,
    input  logic [LEN_W-1:0]  max_payload,
    output result_t           result
);

    logic [HDR_CNT_W-1:0] hdr_count_reg, hdr_count_next;
    logic [23:0]          len_low_reg, len_low_next;
    logic [LEN_W-1:0]     remaining_reg, remaining_next;
    logic                 too_large_reg, too_large_next;
    logic                 overrun_reg, overrun_next;

    logic             hdr_done, in_header, header_last, in_payload;
    logic [LEN_W-1:0] full_len, remaining_dec;
    logic             too_large_now, too_large, short_payload, utf8_bad, utf8_step;

    assign hdr_done      = (hdr_count_reg == HDR_BYTES);
    assign in_header     = !hdr_done;
    assign header_last   = in_header && (hdr_count_reg == HDR_LAST_INDEX);
    assign in_payload    = hdr_done && (remaining_reg != '0);
    assign full_len      = {data_byte, len_low_reg};
    assign too_large_now = (full_len > max_payload);
    assign remaining_dec = remaining_reg - 32'd1;
    assign utf8_step     = advance && in_payload;

    lpfd_utf8 u_utf8 (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (utf8_step),
        .clear     (advance && buffer_end),
        .data_byte (data_byte),
        .bad_next  (utf8_bad)
    );

    always_comb
    begin
        hdr_count_next = hdr_count_reg;
        len_low_next   = len_low_reg;
        remaining_next = remaining_reg;
        too_large_next = too_large_reg;
        overrun_next   = overrun_reg;

        if (in_header)
        begin
            hdr_count_next = hdr_count_reg + 3'd1;
            case (hdr_count_reg[1:0])
                2'd0:    len_low_next[7:0]   = data_byte;
                2'd1:    len_low_next[15:8]  = data_byte;
                2'd2:    len_low_next[23:16] = data_byte;
                default:
                begin
                    remaining_next = full_len;
                    too_large_next = too_large_now;
                end
            endcase
        end
        else if (in_payload)
        begin
            remaining_next = remaining_dec;
        end
        else
        begin
            overrun_next = 1'b1;
        end

        too_large     = header_last ? too_large_now : too_large_reg;
        short_payload = header_last ? (full_len != '0)
                                    : (in_payload && (remaining_dec != '0));

        result.payload_valid = in_payload;
        result.payload_byte  = in_payload ? data_byte : '0;
        result.status_valid  = buffer_end;
        result.status        = STATUS_OK;
        if (buffer_end)
        begin
            if (in_header && !header_last)
                result.status = STATUS_TRUNCATED;
            else if (too_large)
                result.status = STATUS_TOO_LARGE;
            else if (short_payload)
                result.status = STATUS_TRUNCATED;
            else if (overrun_next)
                result.status = STATUS_EXCESS;
            else if (utf8_bad)
                result.status = STATUS_BAD_UTF8;
            else
                result.status = STATUS_OK;
        end
    end

    // Assembled length bytes are rewritten before each use
    always_ff @(posedge clk)
    begin
        if (advance)
            len_low_reg <= len_low_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg <= '0;
            remaining_reg <= '0;
            too_large_reg <= 1'b0;
            overrun_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (buffer_end)
            begin
                hdr_count_reg <= '0;
                remaining_reg <= '0;
                too_large_reg <= 1'b0;
                overrun_reg   <= 1'b0;
            end
            else
            begin
                hdr_count_reg <= hdr_count_next;
                remaining_reg <= remaining_next;
                too_large_reg <= too_large_next;
                overrun_reg   <= overrun_next;
            end
        end
    end

endmodule

// ----- hw/rtl/length_prefixed_frame_decoder_core.sv -----
// Length-prefixed frame decoder: takes a received buffer one byte per item, the
// first four bytes a little-endian payload length, and gives one result item per
// byte. Payload bytes within the declared length come out unchanged with
// payload_valid set; they are not held back, so drop them unless the status on the
// buffer's last byte is ok. The last byte (buffer_end) carries status_valid and the
// verdict: truncated header, then too large (length above max_payload_bytes), then
// short payload (truncated), then excess bytes, then invalid UTF-8 (strict: no
// overlongs, surrogates, values above 0x10FFFF, or sequence cut short), else ok.
// One byte is accepted every clock cycle unless the output stalls; each byte passes
// through the input register and then the result register, which bracket the
// combinational frame and UTF-8 decode, before its result is offered. Output
// stalls back up through both registers. max_payload_bytes sits at APB byte address
// 0 (reset 1048576); write it only while no buffer is in flight. Depends on lpfd_pkg,
// the lpfd interfaces, lpfd_frame, lpfd_utf8 and the assertion macro header.
`include "length_prefixed_frame_decoder_core_defines.svh"

module length_prefixed_frame_decoder_core import lpfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    lpfd_byte_if.sink           byte_ch,
    lpfd_result_if.source       result_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [LEN_W-1:0] max_payload_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_write)
            max_payload_reg <= pwdata;
    end

    // Byte offset bits are ignored; anything past the one register reads zero
    always_comb
    begin
        if (paddr[2] == REG_MAX_PAYLOAD)
            prdata = max_payload_reg;
        else
            prdata = '0;
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_end_reg;
    logic              out_free, advance, accept;

    // The result slot frees when empty or when its item is taken this cycle
    assign out_free      = !result_ch.valid || result_ch.ready;
    assign advance       = s1_valid_reg && out_free;
    assign byte_ch.ready = !s1_valid_reg || out_free;
    assign accept        = byte_ch.valid && byte_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= byte_ch.data_byte;
            s1_end_reg  <= byte_ch.buffer_end;
        end
    end

    // ---------------------------------------------------------------
    // Frame state and verdict
    // ---------------------------------------------------------------
    result_t frame_result;

    lpfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .data_byte   (s1_byte_reg),
        .buffer_end  (s1_end_reg),
        .max_payload (max_payload_reg),
        .result      (frame_result)
    );

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic    out_valid_reg;
    result_t out_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= frame_result;
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.payload_valid = out_result_reg.payload_valid;
    assign result_ch.payload_byte  = out_result_reg.payload_byte;
    assign result_ch.status_valid  = out_result_reg.status_valid;
    assign result_ch.status        = out_result_reg.status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // With both registers full and the output stalled, no byte may enter
    `LPFD_ASSERT(a_no_accept_when_full,
        s1_valid_reg && result_ch.valid && !result_ch.ready |-> !byte_ch.ready,
        "byte accepted while both pipeline registers are full")
    // A verdict only rides on the last byte of a buffer
    `LPFD_ASSERT(a_status_only_at_end,
        result_ch.valid && !result_ch.status_valid |-> result_ch.status == STATUS_OK,
        "status nonzero on a byte that does not end a buffer")
    // Bytes outside the payload come out as zero
    `LPFD_ASSERT(a_payload_zero_outside,
        result_ch.valid && !result_ch.payload_valid |-> result_ch.payload_byte == '0,
        "payload byte nonzero outside the declared payload")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for length_prefixed_frame_decoder_core: directed and random
// buffers, a byte-level decode predictor, a bursty byte driver and a stalling result monitor.
// Depends on lpfd_pkg, the lpfd channel interfaces and the decoder RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfd_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_MAX_PAYLOAD = 3'd0;
    // No register lives here; writes must be dropped by the block
    localparam logic [PADDR_W-1:0] ADDR_UNUSED      = 3'd4;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } buf_byte_t;

    logic clk;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lpfd_byte_if   byte_ch ();
    lpfd_result_if result_ch ();

    length_prefixed_frame_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Bytes waiting to be offered, and decoder results predicted for accepted bytes
    buf_byte_t         tx_items[$];
    result_t           exp_results[$];
    logic [BYTE_W-1:0] pay_q[$];

    // Predictor copy of the decoder state and its length limit
    logic [LEN_W-1:0]     max_len;
    logic [HDR_CNT_W-1:0] hdr_cnt;
    logic [LEN_W-1:0]     decl_len;
    logic [LEN_W-1:0]     pay_cnt;
    logic                 overrun;
    logic [1:0]           u_pend;
    utf8_range_t          u_range;
    logic                 u_err;

    // Idling controls; the stimulus process changes all but hold_seen, on falling edges only
    bit tx_bursty;
    bit rx_stalls;
    bit sender_hold;
    bit hold_trigger;
    bit hold_seen;

    int        burst_left;
    int        gap_left;
    buf_byte_t tx_next;
    int        rx_left;
    bit        rx_open;
    int        hold_left;
    result_t   want;

    int errors;
    int cfg_errors;
    int items_queued;
    int bytes_checked;
    int buffers_checked;
    int limits_used;
    int verdicts[5];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_frame_model();
        hdr_cnt  = '0;
        decl_len = '0;
        pay_cnt  = '0;
        overrun  = 1'b0;
        u_pend   = '0;
        u_range  = RANGE_NORMAL;
        u_err    = 1'b0;
    endfunction

    // Advance the strict UTF-8 checker by one payload byte
    function automatic void utf8_step(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (u_pend != 0) begin
            if (u_range == RANGE_RAISED)
                lo = (u_pend == 2) ? 8'hA0 : 8'h90;
            else if (u_range == RANGE_LOWERED)
                hi = (u_pend == 2) ? 8'h9F : 8'h8F;
            if (b < lo || b > hi) begin
                u_err  = 1'b1;
                u_pend = '0;
            end else begin
                u_pend = u_pend - 2'd1;
            end
            u_range = RANGE_NORMAL;
        end else begin
            u_range = RANGE_NORMAL;
            if (b <= 8'h7F) begin
                u_pend = '0;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
                u_pend = 2'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                u_pend = 2'd2;
                if (b == 8'hE0)
                    u_range = RANGE_RAISED;
                else if (b == 8'hED)
                    u_range = RANGE_LOWERED;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                u_pend = 2'd3;
                if (b == 8'hF0)
                    u_range = RANGE_RAISED;
                else if (b == 8'hF4)
                    u_range = RANGE_LOWERED;
            end else begin
                u_err = 1'b1;
            end
        end
    endfunction

    // Work out the result item one accepted byte causes
    function automatic result_t decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        result_t r;
        r = '0;
        if (hdr_cnt < HDR_BYTES) begin
            decl_len = decl_len | ({24'd0, b} << (8 * hdr_cnt));
            hdr_cnt  = hdr_cnt + 3'd1;
        end else if (pay_cnt < decl_len) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            pay_cnt         = pay_cnt + 32'd1;
            utf8_step(b);
        end else begin
            overrun = 1'b1;
        end
        if (last) begin
            r.status_valid = 1'b1;
            if (hdr_cnt < HDR_BYTES)
                r.status = STATUS_TRUNCATED;
            else if (decl_len > max_len)
                r.status = STATUS_TOO_LARGE;
            else if (pay_cnt < decl_len)
                r.status = STATUS_TRUNCATED;
            else if (overrun)
                r.status = STATUS_EXCESS;
            else if (u_err || u_pend != 0)
                r.status = STATUS_BAD_UTF8;
            else
                r.status = STATUS_OK;
            clear_frame_model();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte driver: offer queued items in bursts, hold each item until taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_ch.valid      <= 1'b0;
            byte_ch.data_byte  <= '0;
            byte_ch.buffer_end <= 1'b0;
            burst_left         <= 1;
            gap_left           <= 0;
            clear_frame_model();
        end else begin
            // Predict from the item that was taken at this edge
            if (byte_ch.valid && byte_ch.ready)
                exp_results.insert(exp_results.size(),
                                   decode_byte(byte_ch.data_byte, byte_ch.buffer_end));
            // The bus may change only when empty or just accepted
            if (!byte_ch.valid || byte_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    byte_ch.valid <= 1'b0;
                end else if (tx_items.size() != 0 && !sender_hold) begin
                    tx_next = tx_items[0];
                    tx_items.delete(0);
                    byte_ch.valid      <= 1'b1;
                    byte_ch.data_byte  <= tx_next.data;
                    byte_ch.buffer_end <= tx_next.last;
                    // End of burst: pick the next burst and the gap before it
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= tx_bursty ? $urandom_range(1, 6) : 0;
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here and started by a toggle
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_trigger != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_trigger;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each taken item against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            rx_left         <= 0;
            rx_open         <= 1'b1;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (exp_results.size() == 0) begin
                    $error("result item arrived with no prediction pending");
                    errors++;
                end else begin
                    want = exp_results[0];
                    exp_results.delete(0);
                    bytes_checked++;
                    if (result_ch.payload_valid !== want.payload_valid) begin
                        $error("payload_valid: expected %0d, got %0d",
                               want.payload_valid, result_ch.payload_valid);
                        errors++;
                    end
                    if (result_ch.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected 0x%02h, got 0x%02h",
                               want.payload_byte, result_ch.payload_byte);
                        errors++;
                    end
                    if (result_ch.status_valid !== want.status_valid) begin
                        $error("status_valid: expected %0d, got %0d",
                               want.status_valid, result_ch.status_valid);
                        errors++;
                    end
                    if (result_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, result_ch.status);
                        errors++;
                    end
                    if (want.status_valid) begin
                        buffers_checked++;
                        verdicts[want.status]++;
                    end
                end
            end
            // Alternate open and stalled stretches of random length
            if (rx_left != 0) begin
                rx_left <= rx_left - 1;
            end else begin
                rx_open <= !rx_open;
                rx_left <= rx_open ? $urandom_range(0, 4) : $urandom_range(0, 15);
            end
            result_ch.ready <= (hold_left == 0) && (rx_open || !rx_stalls);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] rand_in(input logic [BYTE_W-1:0] lo,
                                                  input logic [BYTE_W-1:0] hi);
        return BYTE_W'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    // Append one well-formed UTF-8 character to the payload
    task automatic add_valid_char();
        logic [BYTE_W-1:0] lead;
        int                pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            pay_q.insert(pay_q.size(), rand_in(8'h00, 8'h7F));
        end else if (pick < 6) begin
            pay_q.insert(pay_q.size(), rand_in(8'hC2, 8'hDF));
            pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
        end else if (pick < 8) begin
            lead = rand_in(8'hE0, 8'hEF);
            pay_q.insert(pay_q.size(), lead);
            if (lead == 8'hE0)
                pay_q.insert(pay_q.size(), rand_in(8'hA0, 8'hBF));
            else if (lead == 8'hED)
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'h9F));
            else
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
        end else begin
            lead = rand_in(8'hF0, 8'hF4);
            pay_q.insert(pay_q.size(), lead);
            if (lead == 8'hF0)
                pay_q.insert(pay_q.size(), rand_in(8'h90, 8'hBF));
            else if (lead == 8'hF4)
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'h8F));
            else
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
        end
    endtask

    // Append one ill-formed sequence: overlong, surrogate, out of range, stray or cut short
    task automatic add_bad_seq();
        case ($urandom_range(0, 7))
            0: begin
                pay_q.insert(pay_q.size(), rand_in(8'hC0, 8'hC1));
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            end
            1: pay_q.insert(pay_q.size(), rand_in(8'hF5, 8'hFF));
            2: pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            3: begin
                pay_q.insert(pay_q.size(), 8'hE0);
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'h9F));
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            end
            4: begin
                pay_q.insert(pay_q.size(), 8'hED);
                pay_q.insert(pay_q.size(), rand_in(8'hA0, 8'hBF));
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            end
            5: begin
                pay_q.insert(pay_q.size(), 8'hF0);
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'h8F));
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            end
            6: begin
                pay_q.insert(pay_q.size(), 8'hF4);
                pay_q.insert(pay_q.size(), rand_in(8'h90, 8'hBF));
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
                pay_q.insert(pay_q.size(), rand_in(8'h80, 8'hBF));
            end
            default: begin
                // Lead byte left without its continuation
                pay_q.insert(pay_q.size(), rand_in(8'hC2, 8'hF4));
            end
        endcase
    endtask

    // Queue hdr_n header bytes of decl, the whole payload, then extra trailing bytes
    task automatic emit_buffer(input logic [LEN_W-1:0] decl, input int hdr_n, input int extra);
        buf_byte_t item;
        int        total;
        int        n;
        total = hdr_n + pay_q.size() + extra;
        n     = 0;
        for (int i = 0; i < total; i++) begin
            if (i < hdr_n)
                item.data = decl[8*i +: 8];
            else if (i < hdr_n + pay_q.size())
                item.data = pay_q[i - hdr_n];
            else
                item.data = rand_in(8'h00, 8'hFF);
            n++;
            item.last = (n == total);
            tx_items.insert(tx_items.size(), item);
        end
        items_queued += total;
    endtask

    // Build one random buffer; most are well formed so the UTF-8 checker is exercised deeply
    task automatic random_buffer();
        int               roll;
        int               nchar;
        int               size;
        logic [LEN_W-1:0] decl;
        pay_q.delete();
        roll  = $urandom_range(0, 99);
        nchar = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 6);
        if (roll >= 55 && roll < 63) begin
            repeat ($urandom_range(1, 10)) pay_q.insert(pay_q.size(), rand_in(8'h00, 8'hFF));
        end else begin
            repeat (nchar) add_valid_char();
            if (roll >= 90) begin
                add_bad_seq();
                repeat ($urandom_range(0, 2)) add_valid_char();
            end
        end
        size = pay_q.size();
        if (roll < 63 || roll >= 90) begin
            emit_buffer(size, 4, 0);
        end else if (roll < 68) begin
            // Header cut short
            pay_q.delete();
            emit_buffer($urandom, $urandom_range(1, 3), 0);
        end else if (roll < 76) begin
            // Payload shorter than declared
            decl = ($urandom_range(0, 3) == 0) ? $urandom : size + $urandom_range(1, 3);
            emit_buffer(decl, 4, 0);
        end else if (roll < 84) begin
            emit_buffer(size, 4, $urandom_range(1, 4));
        end else begin
            // Declared length just past the limit (wraps to a small length under the largest limit)
            emit_buffer(max_len + $urandom_range(1, 4), 4, 0);
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = items_queued + n;
        while (items_queued < target)
            random_buffer();
    endtask

    // Wait until every item has been offered, taken and checked, then let the pipe settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (tx_items.size() != 0 || byte_ch.valid || exp_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_PAYLOAD)
            max_len = data;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the length limit while idle, poke the unused address, and read the limit back
    task automatic set_limit(input logic [LEN_W-1:0] value);
        logic [PDATA_W-1:0] rd;
        apb_write(ADDR_MAX_PAYLOAD, value);
        apb_write(ADDR_UNUSED, $urandom);
        apb_read(ADDR_MAX_PAYLOAD, rd);
        if (rd !== max_len) begin
            $error("max_payload_bytes: expected 0x%08h, got 0x%08h", max_len, rd);
            cfg_errors++;
        end
        limits_used++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        tx_bursty    = 1'b1;
        rx_stalls    = 1'b1;
        sender_hold  = 1'b0;
        hold_trigger = 1'b0;
        max_len      = MAX_PAYLOAD_RESET;
        limits_used  = 1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed buffers under the reset limit
        pay_q = '{8'h00, 8'h00, 8'h00, 8'h00};                   // empty payload, ok
        emit_buffer(0, 0, 0);
        pay_q = '{8'hAB};                                        // header cut short
        emit_buffer(0, 0, 0);
        pay_q = '{8'h02, 8'h00, 8'h00, 8'h00, 8'hED, 8'hA0};     // surrogate
        emit_buffer(0, 0, 0);
        pay_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hF5, 8'h7F};     // excess beats bad lead
        emit_buffer(0, 0, 0);
        pay_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};                   // largest length
        emit_buffer(0, 0, 0);
        pay_q = '{8'h04, 8'h00, 8'h00, 8'h00, 8'hF4, 8'h8F, 8'hBF, 8'hBF}; // U+10FFFF, ok
        emit_buffer(0, 0, 0);
        wait_drained();

        // Reset limit, ordinary idling
        run_random(100);
        wait_drained();

        // Zero limit: only empty payloads pass
        set_limit(32'd0);
        run_random(100);
        wait_drained();

        // Largest limit, with a long receiver hold while the sender streams
        set_limit(32'hFFFF_FFFF);
        tx_bursty = 1'b0;
        run_random(180);
        @(negedge clk);
        hold_trigger = !hold_trigger;
        wait_drained();
        tx_bursty = 1'b1;

        // Small limit, with the sender paused mid-stream until the pipe empties
        set_limit($urandom_range(0, 12));
        run_random(70);
        while (tx_items.size() > 40)
            @(negedge clk);
        sender_hold = 1'b1;
        do
            @(negedge clk);
        while (byte_ch.valid || exp_results.size() != 0);
        sender_hold = 1'b0;
        run_random(70);
        wait_drained();

        // Full rate on both sides
        set_limit(32'd8);
        tx_bursty = 1'b0;
        rx_stalls = 1'b0;
        run_random(120);
        wait_drained();

        // Back to the reset value with idling restored
        tx_bursty = 1'b1;
        rx_stalls = 1'b1;
        set_limit(MAX_PAYLOAD_RESET);
        run_random(60);
        wait_drained();
        repeat (8) @(negedge clk);

        $display("Checked %0d result items in %0d buffers under %0d length limits",
                 bytes_checked, buffers_checked, limits_used);
        $display("Verdicts: ok %0d, truncated %0d, too large %0d, excess %0d, bad utf8 %0d",
                 verdicts[0], verdicts[1], verdicts[2], verdicts[3], verdicts[4]);
        if (errors == 0 && cfg_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
